FILE: hw/rtl/gda_pkg.sv
// gda_pkg: shared types, codes, calendar constants and month tables for the
// gregorian date pipeline. No dependencies.
package gda_pkg;

  localparam int MAX_YEAR_DEF = 4095;

  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int AMT_W    = 21;
  localparam int SERIAL_W = 20;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // days from 0001-01-01 to 1900-01-01
  localparam int DBY_1900  = 693595;
  // days from 1600-03-01 to the day before serial 1
  localparam int EPOCH_OFS = 109512;
  localparam int ERA_DAYS  = 146097;
  localparam int ERA_MAX   = 6;
  localparam int ERA_W     = 3;
  localparam int DOE_W     = 18;
  localparam int YOE_W     = 9;
  localparam int DOY_W     = 9;

  typedef enum logic [OP_W-1:0] {
    OP_TO_SERIAL   = 2'd0,
    OP_FROM_SERIAL = 2'd1,
    OP_ADD         = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [SERIAL_W-1:0]   serial;
  } gda_ser_t;

  typedef struct packed {
    status_t               status;
    logic [YEAR_W-1:0]     year;
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;
    logic [SERIAL_W-1:0]   serial;
  } gda_date_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of month m in a january-based year
  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m,
                                             input logic leap);
    logic [8:0] base;
    case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // days before month index mp of a march-based year (march is index 0)
  function automatic logic [DOY_W-1:0] mar_start(input logic [3:0] mp);
    logic [DOY_W-1:0] base;
    case (mp)
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

FILE: hw/rtl/gda_encode.sv
// gda_encode: four-stage front end; checks the input date, forms its serial
// day number, applies the offset and sets the status. Depends on gda_pkg.
module gda_encode #(
  parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_vld,
  input  gda_pkg::op_t                         in_op,
  input  logic [gda_pkg::YEAR_W-1:0]           in_year,
  input  logic [gda_pkg::MONTH_W-1:0]          in_month,
  input  logic [gda_pkg::DAY_W-1:0]            in_day,
  input  logic signed [gda_pkg::AMT_W-1:0]     in_amt,
  output logic                                 out_vld,
  output gda_pkg::gda_ser_t                    out_res
);
  import gda_pkg::*;

  localparam int MaxSerial = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                             + MAX_YEAR / 400 - DBY_1900;
  localparam int Rcp100K   = 19;
  localparam int Rcp100    = (2**Rcp100K + 99) / 100;
  localparam int ProdW     = YEAR_W + 13;
  localparam int SumW      = SERIAL_W + 3;

  // stage 1
  logic                    v1_r;
  op_t                     op1_r;
  logic [YEAR_W-1:0]       year1_r, n1_r;
  logic [MONTH_W-1:0]      month1_r;
  logic [DAY_W-1:0]        day1_r;
  logic signed [AMT_W-1:0] amt1_r;
  logic [5:0]              qn1_r, qy1_r;
  logic [YEAR_W-1:0]       n1_nxt;
  logic [ProdW-1:0]        pn, py;

  // stage 2
  logic                    v2_r, ok2_r;
  op_t                     op2_r;
  logic signed [AMT_W-1:0] amt2_r;
  logic [20:0]             dby2_r, dby2_nxt;
  logic [8:0]              moff2_r, moff2_nxt;
  logic                    ok2_nxt, leap;
  logic [YEAR_W-1:0]       rem100;

  // stage 3
  logic                    v3_r, ok3_r;
  op_t                     op3_r;
  logic signed [AMT_W-1:0] amt3_r;
  logic [SERIAL_W-1:0]     s3_r, s3_nxt;

  // stage 4
  logic                    v4_r;
  gda_ser_t                res4_r, res4_nxt;
  logic signed [SumW-1:0]  base, addend, total;

  always_comb begin
    n1_nxt = in_year - 12'd1;
    pn     = ProdW'(n1_nxt) * ProdW'(Rcp100);
    py     = ProdW'(in_year) * ProdW'(Rcp100);
  end

  always_comb begin
    rem100 = year1_r - YEAR_W'(qy1_r) * YEAR_W'(100);
    leap   = (year1_r[1:0] == 2'b00) && ((rem100 != '0) || (qy1_r[1:0] == 2'b00));
    dby2_nxt = 21'(n1_r) * 21'(365) + 21'(n1_r[YEAR_W-1:2]) - 21'(qn1_r)
               + 21'(qn1_r[5:2]);
    moff2_nxt = month_start(month1_r, leap) + 9'(day1_r);
    ok2_nxt = (year1_r >= 12'd1900) && (year1_r <= YEAR_W'(MAX_YEAR)) &&
              (month1_r >= 4'd1) && (month1_r <= 4'd12) &&
              (day1_r >= 5'd1) && (day1_r <= month_len(month1_r, leap));
  end

  always_comb begin
    s3_nxt = SERIAL_W'(dby2_r - 21'(DBY_1900) + 21'(moff2_r));
  end

  always_comb begin
    base   = (op3_r == OP_FROM_SERIAL) ? '0 : $signed(SumW'(s3_r));
    addend = (op3_r == OP_TO_SERIAL) ? '0 : SumW'(amt3_r);
    total  = base + addend;
    res4_nxt.serial = total[SERIAL_W-1:0];
    if ((total < $signed(SumW'(1))) || (total > $signed(SumW'(MaxSerial)))) begin
      res4_nxt.status = ST_RANGE;
    end else begin
      res4_nxt.status = ST_OK;
    end
    case (op3_r)
      OP_NONE: begin
        res4_nxt.status = ST_INVALID;
      end
      OP_FROM_SERIAL: begin
      end
      default: begin
        if (!ok3_r) begin
          res4_nxt.status = ST_INVALID;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r    <= in_op;
      year1_r  <= in_year;
      n1_r     <= n1_nxt;
      month1_r <= in_month;
      day1_r   <= in_day;
      amt1_r   <= in_amt;
      qn1_r    <= pn[Rcp100K +: 6];
      qy1_r    <= py[Rcp100K +: 6];

      op2_r    <= op1_r;
      amt2_r   <= amt1_r;
      dby2_r   <= dby2_nxt;
      moff2_r  <= moff2_nxt;
      ok2_r    <= ok2_nxt;

      op3_r    <= op2_r;
      amt3_r   <= amt2_r;
      ok3_r    <= ok2_r;
      s3_r     <= s3_nxt;

      res4_r   <= res4_nxt;
    end
  end

  assign out_vld = v4_r;
  assign out_res = res4_r;

endmodule

FILE: hw/rtl/gda_decode.sv
// gda_decode: seven-stage back end; splits a serial day number into year,
// month and day using 400-year eras from 1600-03-01. Depends on gda_pkg.
module gda_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  gda_pkg::gda_ser_t   in_res,
  output logic                out_vld,
  output gda_pkg::gda_date_t  out_date
);
  import gda_pkg::*;

  localparam int Rcp1460K = 29;
  localparam int Rcp1460  = (2**Rcp1460K + 1459) / 1460;
  localparam int Rcp365K  = 27;
  localparam int Rcp365   = (2**Rcp365K + 364) / 365;
  localparam int ProdW    = DOE_W + 19;
  localparam int Stages   = 7;

  logic [Stages-1:0]   v_r;

  // d1
  gda_ser_t            t1_r;
  logic [SERIAL_W-1:0] z1_r, z1_nxt;
  logic [ERA_W-1:0]    era1_r, era1_nxt;

  // d2
  gda_ser_t            t2_r;
  logic [ERA_W-1:0]    era2_r;
  logic [DOE_W-1:0]    doe2_r, doe2_nxt;
  logic [SERIAL_W-1:0] era_base;

  // d3
  gda_ser_t            t3_r;
  logic [ERA_W-1:0]    era3_r;
  logic [DOE_W-1:0]    doe3_r;
  logic [6:0]          q1460_r;
  logic [2:0]          q36524_r, q36524_nxt;
  logic                q146096_r;
  logic [ProdW-1:0]    p1460;

  // d4
  gda_ser_t            t4_r;
  logic [ERA_W-1:0]    era4_r;
  logic [DOE_W-1:0]    doe4_r, num4_r, num4_nxt;

  // d5
  gda_ser_t            t5_r;
  logic [ERA_W-1:0]    era5_r;
  logic [DOE_W-1:0]    doe5_r;
  logic [YOE_W-1:0]    yoe5_r;
  logic [ProdW-1:0]    p365;

  // d6
  gda_ser_t            t6_r;
  logic [ERA_W-1:0]    era6_r;
  logic [YOE_W-1:0]    yoe6_r;
  logic [DOY_W-1:0]    doy6_r, doy6_nxt;
  logic [1:0]          yq100;

  // d7
  gda_date_t           d7_r, d7_nxt;
  logic [3:0]          mp;
  logic [YEAR_W-1:0]   yr;

  always_comb begin
    era1_nxt = '0;
    for (int k = 1; k <= ERA_MAX; k++) begin
      if (in_res.serial >= SERIAL_W'(k * ERA_DAYS - EPOCH_OFS)) begin
        era1_nxt = era1_nxt + ERA_W'(1);
      end
    end
    z1_nxt = in_res.serial + SERIAL_W'(EPOCH_OFS);
  end

  always_comb begin
    era_base = SERIAL_W'(era1_r) * SERIAL_W'(ERA_DAYS);
    doe2_nxt = DOE_W'(z1_r - era_base);
  end

  always_comb begin
    p1460 = ProdW'(doe2_r) * ProdW'(Rcp1460);
    q36524_nxt = 3'(doe2_r >= DOE_W'(36524)) + 3'(doe2_r >= DOE_W'(73048))
               + 3'(doe2_r >= DOE_W'(109572)) + 3'(doe2_r >= DOE_W'(146096));
  end

  always_comb begin
    num4_nxt = doe3_r - DOE_W'(q1460_r) + DOE_W'(q36524_r) - DOE_W'(q146096_r);
  end

  always_comb begin
    p365 = ProdW'(num4_r) * ProdW'(Rcp365);
  end

  always_comb begin
    yq100 = 2'(yoe5_r >= 9'd100) + 2'(yoe5_r >= 9'd200) + 2'(yoe5_r >= 9'd300);
    doy6_nxt = DOY_W'(doe5_r - (DOE_W'(yoe5_r) * DOE_W'(365)
                                + DOE_W'(yoe5_r[YOE_W-1:2]) - DOE_W'(yq100)));
  end

  always_comb begin
    mp = '0;
    for (int k = 1; k <= 11; k++) begin
      if (doy6_r >= mar_start(4'(k))) begin
        mp = mp + 4'd1;
      end
    end
    yr = 12'd1600 + YEAR_W'(era6_r) * YEAR_W'(400) + YEAR_W'(yoe6_r)
         + YEAR_W'(mp >= 4'd10);
    d7_nxt.status = t6_r.status;
    d7_nxt.serial = t6_r.serial;
    d7_nxt.year   = yr;
    d7_nxt.month  = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
    d7_nxt.day    = DAY_W'(doy6_r - mar_start(mp) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[Stages-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r      <= in_res;
      z1_r      <= z1_nxt;
      era1_r    <= era1_nxt;

      t2_r      <= t1_r;
      era2_r    <= era1_r;
      doe2_r    <= doe2_nxt;

      t3_r      <= t2_r;
      era3_r    <= era2_r;
      doe3_r    <= doe2_r;
      q1460_r   <= p1460[Rcp1460K +: 7];
      q36524_r  <= q36524_nxt;
      q146096_r <= (doe2_r == DOE_W'(146096));

      t4_r      <= t3_r;
      era4_r    <= era3_r;
      doe4_r    <= doe3_r;
      num4_r    <= num4_nxt;

      t5_r      <= t4_r;
      era5_r    <= era4_r;
      doe5_r    <= doe4_r;
      yoe5_r    <= p365[Rcp365K +: YOE_W];

      t6_r      <= t5_r;
      era6_r    <= era5_r;
      yoe6_r    <= yoe5_r;
      doy6_r    <= doy6_nxt;

      d7_r      <= d7_nxt;
    end
  end

  assign out_vld  = v_r[Stages-1];
  assign out_date = d7_r;

endmodule

FILE: hw/rtl/gregorian_date_arithmetic.sv
// gregorian_date_arithmetic: top level; stream handshake, output register and
// the encode and decode pipelines. Depends on gda_pkg, gda_encode, gda_decode.
//
// Gregorian date engine with serial day 1 at 1900-01-01. A request carries an
// op in in_tuser (date to serial, serial to date, or date plus a signed day
// offset); a new request is accepted every cycle while the output side keeps
// up. Each result passes through four encode stages, seven decode stages and
// the output register. A stall on out_tready holds the whole pipeline. Results
// whose status is not ok carry zero date and serial fields.
module gregorian_date_arithmetic #(
  parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // year[11:0], month[15:12], day[20:16], amount[41:21]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_year[11:0], out_month[15:12], out_day[20:16],
                                  // out_serial[40:21]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import gda_pkg::*;

  logic      adv;
  logic      enc_vld, dec_vld;
  gda_ser_t  enc_res;
  gda_date_t dec_date;

  logic      out_vld_r;
  gda_date_t out_r, out_nxt;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  gda_encode #(
    .MAX_YEAR (MAX_YEAR)
  ) u_enc (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_tvalid),
    .in_op    (op_t'(in_tuser)),
    .in_year  (in_tdata[11:0]),
    .in_month (in_tdata[15:12]),
    .in_day   (in_tdata[20:16]),
    .in_amt   ($signed(in_tdata[41:21])),
    .out_vld  (enc_vld),
    .out_res  (enc_res)
  );

  gda_decode u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (enc_vld),
    .in_res   (enc_res),
    .out_vld  (dec_vld),
    .out_date (dec_date)
  );

  always_comb begin
    out_nxt = dec_date;
    if (dec_date.status != ST_OK) begin
      out_nxt.year   = '0;
      out_nxt.month  = '0;
      out_nxt.day    = '0;
      out_nxt.serial = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dec_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_r.serial, out_r.day, out_r.month, out_r.year};
  assign out_tuser  = out_r.status;

endmodule
